// ===== rtl/ddwp_pkg.sv =====
// shared types, constants and saturation helpers for the wheel velocity controller
package ddwp_pkg;

	localparam int STEP_W  = 5;
	localparam int MUL_W   = 34;
	localparam int PROD_W  = 68;
	localparam int WORK_W  = 50;
	localparam int TURN_W  = 36;
	localparam int TGT_W   = 38;
	localparam int CIDX_W  = 3;

	// item kinds
	localparam logic [1:0] FUNC_CMD  = 2'd0;
	localparam logic [1:0] FUNC_ENC  = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_SPEED_SCALE = 3'd0;
	localparam logic [CIDX_W-1:0] REG_HALF_TRACK  = 3'd1;
	localparam logic [CIDX_W-1:0] REG_GAIN_P      = 3'd2;
	localparam logic [CIDX_W-1:0] REG_GAIN_I      = 3'd3;
	localparam logic [CIDX_W-1:0] REG_GAIN_D      = 3'd4;

	// configuration reset values
	localparam logic [31:0] RST_SPEED_SCALE = 32'd505270;
	localparam logic [19:0] RST_HALF_TRACK  = 20'd22348;
	localparam logic [31:0] RST_GAIN_P      = 32'd107374182;
	localparam logic [31:0] RST_GAIN_I      = 32'd10737;
	localparam logic [31:0] RST_GAIN_D      = 32'd10737418;

	// 100 percent in 1/256 percent units, and 1.0 of the duty accumulator
	localparam logic signed [MUL_W-1:0] DUTY_FULL  = 34'sd25600;
	localparam logic signed [MUL_W-1:0] DUTY_ONE   = 34'sh1_0000_0000;

	// microprogram addresses
	localparam logic [STEP_W-1:0] ST_ENC_SEED     = 5'd0;
	localparam logic [STEP_W-1:0] ST_ENC_MUL      = 5'd1;
	localparam logic [STEP_W-1:0] ST_ENC_SPEED    = 5'd2;
	localparam logic [STEP_W-1:0] ST_ENC_END      = 5'd3;
	localparam logic [STEP_W-1:0] ST_TK_TURN_MUL  = 5'd4;
	localparam logic [STEP_W-1:0] ST_TK_TURN      = 5'd5;
	localparam logic [STEP_W-1:0] ST_TK_ERR       = 5'd6;
	localparam logic [STEP_W-1:0] ST_TK_SUM       = 5'd7;
	localparam logic [STEP_W-1:0] ST_TK_TP        = 5'd8;
	localparam logic [STEP_W-1:0] ST_TK_TIH       = 5'd9;
	localparam logic [STEP_W-1:0] ST_TK_TIL       = 5'd10;
	localparam logic [STEP_W-1:0] ST_TK_TD        = 5'd11;
	localparam logic [STEP_W-1:0] ST_TK_ADD       = 5'd12;
	localparam logic [STEP_W-1:0] ST_TK_ACC       = 5'd13;
	localparam logic [STEP_W-1:0] ST_TK_DMUL      = 5'd14;
	localparam logic [STEP_W-1:0] ST_TK_DUTY      = 5'd15;
	localparam logic [STEP_W-1:0] ST_TK_EMIT      = 5'd16;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] linear_cmd;
		logic signed [31:0] angular_cmd;
		logic signed [31:0] left_count;
		logic signed [31:0] right_count;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] left_duty;
		logic signed [15:0] right_duty;
		logic signed [31:0] left_speed;
		logic signed [31:0] right_speed;
	} out_word_t;

	typedef struct packed {
		logic [31:0] speed_scale;
		logic [19:0] half_track;
		logic [31:0] gain_p;
		logic [31:0] gain_i;
		logic [31:0] gain_d;
	} cfg_t;

	typedef enum logic [2:0] {
		MA_ZERO, MA_DELTA, MA_ANG, MA_ERR, MA_SUM_HI, MA_SUM_LO, MA_DERR, MA_DUTY
	} mul_a_t;

	typedef enum logic [2:0] {
		MB_ZERO, MB_SCALE, MB_HALF, MB_GP, MB_GI, MB_GD, MB_FULL
	} mul_b_t;

	typedef enum logic [3:0] {
		UOP_NOP, UOP_SEED, UOP_SPEED, UOP_TURN, UOP_ERR, UOP_SUM, UOP_TP,
		UOP_TIH, UOP_TIL, UOP_TD, UOP_ADDP, UOP_ACC, UOP_DUTY, UOP_EMIT
	} uop_t;

	typedef enum logic [1:0] {
		SQ_NEXT, SQ_LOOP, SQ_END
	} seq_t;

	typedef struct packed {
		mul_a_t             mul_a;
		mul_b_t             mul_b;
		uop_t               op;
		seq_t               seq;
		logic [STEP_W-1:0]  target;
	} ctrl_t;

	typedef enum logic {
		SS_IDLE, SS_RUN
	} seq_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
		logic [PROD_W-32:0] hi;
		hi = x[PROD_W-1:31];
		if ((&hi) || !(|hi)) begin
			return x[31:0];
		end else if (x[PROD_W-1]) begin
			return 32'h8000_0000;
		end else begin
			return 32'h7fff_ffff;
		end
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [PROD_W-1:0] x);
		logic [PROD_W-48:0] hi;
		hi = x[PROD_W-1:47];
		if ((&hi) || !(|hi)) begin
			return x[47:0];
		end else if (x[PROD_W-1]) begin
			return 48'h8000_0000_0000;
		end else begin
			return 48'h7fff_ffff_ffff;
		end
	endfunction

endpackage

// ===== rtl/diff_drive_wheel_pid_top.sv =====
// top level: config registers, item handshake, microsequencer and output register
// items are taken only while no encoder or tick program runs; the programs step the
//   single shared 34x34 multiplier through its work for each wheel
// the next item is taken while a finished result still waits in the output register
// reset: asynchronous, active low; clears state, restores register defaults
module diff_drive_wheel_pid_top import ddwp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_word_t          in_word,
	output logic              out_valid,
	input  logic              out_ready,
	output out_word_t         out_word,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [31:0]       cfg_data
);

	cfg_t              cfg_q;
	ctrl_t             ctrl;
	logic [STEP_W-1:0] step;
	logic [STEP_W-1:0] entry;
	logic              wheel, busy, run, stall, start;
	logic              accept, load_cmd, load_enc;
	logic              out_valid_q;
	out_word_t         out_q;
	out_word_t         res;

	// configuration writes, out of range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_scale <= RST_SPEED_SCALE;
			cfg_q.half_track  <= RST_HALF_TRACK;
			cfg_q.gain_p      <= RST_GAIN_P;
			cfg_q.gain_i      <= RST_GAIN_I;
			cfg_q.gain_d      <= RST_GAIN_D;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED_SCALE: cfg_q.speed_scale <= cfg_data;
				REG_HALF_TRACK:  cfg_q.half_track  <= cfg_data[19:0];
				REG_GAIN_P:      cfg_q.gain_p      <= cfg_data;
				REG_GAIN_I:      cfg_q.gain_i      <= cfg_data;
				REG_GAIN_D:      cfg_q.gain_d      <= cfg_data;
				default: ;
			endcase
		end
	end

	// input word: commands are stored at once, encoder and tick words run a program
	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;
	assign load_cmd = accept && (in_word.func == FUNC_CMD);
	assign load_enc = accept && (in_word.func == FUNC_ENC);
	assign start    = accept && ((in_word.func == FUNC_ENC) || (in_word.func == FUNC_TICK));
	assign entry    = (in_word.func == FUNC_ENC) ? ST_ENC_SEED : ST_TK_TURN_MUL;

	// the emit step waits while the output register is still full
	assign stall = (ctrl.op == UOP_EMIT) && out_valid_q && !out_ready;

	ddwp_urom u_urom (
		.step (step),
		.ctrl (ctrl)
	);

	ddwp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.entry  (entry),
		.ctrl   (ctrl),
		.stall  (stall),
		.step   (step),
		.wheel  (wheel),
		.busy   (busy),
		.run    (run)
	);

	ddwp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.ctrl     (ctrl),
		.run      (run),
		.wheel    (wheel),
		.load_cmd (load_cmd),
		.load_enc (load_enc),
		.in_word  (in_word),
		.res      (res)
	);

	// output register, loaded by the emit step of a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (run && ctrl.op == UOP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (run && ctrl.op == UOP_EMIT) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

// ===== rtl/ddwp_urom.sv =====
// microprogram rom: one control word per step
module ddwp_urom import ddwp_pkg::*; (
	input  logic [STEP_W-1:0] step,
	output ctrl_t             ctrl
);

	function automatic ctrl_t cw(input mul_a_t a, input mul_b_t b, input uop_t o,
		input seq_t s, input logic [STEP_W-1:0] t);
		ctrl_t c;
		c.mul_a  = a;
		c.mul_b  = b;
		c.op     = o;
		c.seq    = s;
		c.target = t;
		return c;
	endfunction

	always_comb begin
		case (step)
			// encoder sample, loops over both wheels
			ST_ENC_SEED:    ctrl = cw(MA_ZERO,   MB_ZERO,  UOP_SEED,  SQ_NEXT, ST_ENC_SEED);
			ST_ENC_MUL:     ctrl = cw(MA_DELTA,  MB_SCALE, UOP_NOP,   SQ_NEXT, ST_ENC_SEED);
			ST_ENC_SPEED:   ctrl = cw(MA_ZERO,   MB_ZERO,  UOP_SPEED, SQ_LOOP, ST_ENC_MUL);
			ST_ENC_END:     ctrl = cw(MA_ZERO,   MB_ZERO,  UOP_NOP,   SQ_END,  ST_ENC_SEED);
			// control tick
			ST_TK_TURN_MUL: ctrl = cw(MA_ANG,    MB_HALF,  UOP_NOP,   SQ_NEXT, ST_ENC_SEED);
			ST_TK_TURN:     ctrl = cw(MA_ZERO,   MB_ZERO,  UOP_TURN,  SQ_NEXT, ST_ENC_SEED);
			ST_TK_ERR:      ctrl = cw(MA_ZERO,   MB_ZERO,  UOP_ERR,   SQ_NEXT, ST_ENC_SEED);
			ST_TK_SUM:      ctrl = cw(MA_ERR,    MB_GP,    UOP_SUM,   SQ_NEXT, ST_ENC_SEED);
			ST_TK_TP:       ctrl = cw(MA_SUM_HI, MB_GI,    UOP_TP,    SQ_NEXT, ST_ENC_SEED);
			ST_TK_TIH:      ctrl = cw(MA_SUM_LO, MB_GI,    UOP_TIH,   SQ_NEXT, ST_ENC_SEED);
			ST_TK_TIL:      ctrl = cw(MA_DERR,   MB_GD,    UOP_TIL,   SQ_NEXT, ST_ENC_SEED);
			ST_TK_TD:       ctrl = cw(MA_ZERO,   MB_ZERO,  UOP_TD,    SQ_NEXT, ST_ENC_SEED);
			ST_TK_ADD:      ctrl = cw(MA_ZERO,   MB_ZERO,  UOP_ADDP,  SQ_NEXT, ST_ENC_SEED);
			ST_TK_ACC:      ctrl = cw(MA_ZERO,   MB_ZERO,  UOP_ACC,   SQ_NEXT, ST_ENC_SEED);
			ST_TK_DMUL:     ctrl = cw(MA_DUTY,   MB_FULL,  UOP_NOP,   SQ_NEXT, ST_ENC_SEED);
			ST_TK_DUTY:     ctrl = cw(MA_ZERO,   MB_ZERO,  UOP_DUTY,  SQ_LOOP, ST_TK_ERR);
			ST_TK_EMIT:     ctrl = cw(MA_ZERO,   MB_ZERO,  UOP_EMIT,  SQ_END,  ST_ENC_SEED);
			default:        ctrl = cw(MA_ZERO,   MB_ZERO,  UOP_NOP,   SQ_END,  ST_ENC_SEED);
		endcase
	end

endmodule

// ===== rtl/ddwp_seq.sv =====
// step counter, wheel select and jump logic of the microsequencer
module ddwp_seq import ddwp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [STEP_W-1:0] entry,
	input  ctrl_t             ctrl,
	input  logic              stall,
	output logic [STEP_W-1:0] step,
	output logic              wheel,
	output logic              busy,
	output logic              run
);

	seq_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              wheel_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			SS_IDLE: begin
				if (start) begin
					state_d = SS_RUN;
				end
			end
			SS_RUN: begin
				if (!stall && ctrl.seq == SQ_END) begin
					state_d = SS_IDLE;
				end
			end
			default: state_d = SS_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q == SS_RUN);
		run  = busy && !stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SS_IDLE;
			step_q  <= ST_ENC_SEED;
			wheel_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == SS_IDLE) begin
				if (start) begin
					step_q  <= entry;
					wheel_q <= 1'b0;
				end
			end else if (!stall) begin
				case (ctrl.seq)
					SQ_NEXT: step_q <= step_q + STEP_W'(1);
					SQ_LOOP: begin
						// second pass for the right wheel, then fall through
						if (!wheel_q) begin
							wheel_q <= 1'b1;
							step_q  <= ctrl.target;
						end else begin
							wheel_q <= 1'b0;
							step_q  <= step_q + STEP_W'(1);
						end
					end
					SQ_END:  step_q <= step_q;
					default: step_q <= step_q;
				endcase
			end
		end
	end

	assign step  = step_q;
	assign wheel = wheel_q;

endmodule

// ===== rtl/ddwp_dp.sv =====
// datapath: controller state, shared multiplier and the microop register transfers
module ddwp_dp import ddwp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  ctrl_t     ctrl,
	input  logic      run,
	input  logic      wheel,
	input  logic      load_cmd,
	input  logic      load_enc,
	input  in_word_t  in_word,
	output out_word_t res
);

	// controller state
	logic signed [31:0] cmd_lin_q, cmd_ang_q;
	logic [31:0]        prev_q [2];
	logic               first_q;
	logic signed [31:0] speed_q [2];
	logic signed [47:0] esum_q [2];
	logic signed [31:0] elast_q [2];
	logic signed [47:0] acc_q [2];

	// work registers
	logic [31:0]              now_q [2];
	logic signed [15:0]       duty_q [2];
	logic signed [TURN_W-1:0] turn_q;
	logic signed [31:0]       err_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] part_q;
	logic signed [WORK_W-1:0] work_q;

	logic signed [31:0]       delta;
	logic signed [MUL_W-1:0]  duty_c;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [TGT_W-1:0]  lin_w, turn_w, target;
	logic signed [PROD_W-1:0] diff_w, sum_w, acc_w, neg_w;
	logic signed [47:0]       tp48, part48;
	logic signed [WORK_W-1:0] tp_w, part_w;

	always_comb begin
		delta = now_q[wheel] - prev_q[wheel];
		if (acc_q[wheel] > 48'(DUTY_ONE)) begin
			duty_c = DUTY_ONE;
		end else if (acc_q[wheel] < -48'(DUTY_ONE)) begin
			duty_c = -DUTY_ONE;
		end else begin
			duty_c = acc_q[wheel][MUL_W-1:0];
		end
		case (ctrl.mul_a)
			MA_DELTA:  mul_a = MUL_W'(delta);
			MA_ANG:    mul_a = MUL_W'(cmd_ang_q);
			MA_ERR:    mul_a = MUL_W'(err_q);
			MA_SUM_HI: mul_a = MUL_W'($signed(esum_q[wheel][47:16]));
			MA_SUM_LO: mul_a = {18'd0, esum_q[wheel][15:0]};
			MA_DERR:   mul_a = MUL_W'(err_q) - MUL_W'(elast_q[wheel]);
			MA_DUTY:   mul_a = wheel ? -duty_c : duty_c;
			default:   mul_a = '0;
		endcase
		case (ctrl.mul_b)
			MB_SCALE: mul_b = {2'b00, cfg.speed_scale};
			MB_HALF:  mul_b = {14'd0, cfg.half_track};
			MB_GP:    mul_b = {2'b00, cfg.gain_p};
			MB_GI:    mul_b = {2'b00, cfg.gain_i};
			MB_GD:    mul_b = {2'b00, cfg.gain_d};
			MB_FULL:  mul_b = DUTY_FULL;
			default:  mul_b = '0;
		endcase
		prod_d = mul_a * mul_b;
	end

	always_comb begin
		lin_w  = TGT_W'(cmd_lin_q);
		turn_w = TGT_W'(turn_q);
		// right target is mirrored
		target = wheel ? -(lin_w + turn_w) : (lin_w - turn_w);
		diff_w = PROD_W'(target) - PROD_W'(speed_q[wheel]);
		sum_w  = PROD_W'(esum_q[wheel]) + PROD_W'(err_q);
		acc_w  = PROD_W'(acc_q[wheel]) + PROD_W'(work_q);
		neg_w  = -prod_q;
		tp48   = sat48(prod_q >>> 16);
		part48 = sat48(part_q);
		tp_w   = WORK_W'(tp48);
		part_w = WORK_W'(part48);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_lin_q <= '0;
			cmd_ang_q <= '0;
			first_q   <= 1'b1;
			for (int i = 0; i < 2; i++) begin
				prev_q[i]  <= '0;
				speed_q[i] <= '0;
				esum_q[i]  <= '0;
				elast_q[i] <= '0;
				acc_q[i]   <= '0;
			end
		end else begin
			if (load_cmd) begin
				cmd_lin_q <= in_word.linear_cmd;
				cmd_ang_q <= in_word.angular_cmd;
			end
			if (run) begin
				case (ctrl.op)
					UOP_SEED: begin
						// first sample gives zero speed
						if (first_q) begin
							prev_q[0] <= now_q[0];
							prev_q[1] <= now_q[1];
							first_q   <= 1'b0;
						end
					end
					UOP_SPEED: begin
						speed_q[wheel] <= sat32(neg_w >>> 16);
						prev_q[wheel]  <= now_q[wheel];
					end
					UOP_SUM:  esum_q[wheel]  <= sat48(sum_w);
					UOP_TD:   elast_q[wheel] <= err_q;
					UOP_ACC:  acc_q[wheel]   <= sat48(acc_w);
					default: ;
				endcase
			end
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (load_enc) begin
			now_q[0] <= in_word.left_count;
			now_q[1] <= in_word.right_count;
		end
		if (run) begin
			case (ctrl.op)
				UOP_TURN: turn_q <= prod_q[51:16];
				UOP_ERR:  err_q  <= sat32(diff_w);
				UOP_TP:   work_q <= tp_w;
				UOP_TIH:  part_q <= prod_q;
				UOP_TIL:  part_q <= part_q + (prod_q >>> 16);
				UOP_TD: begin
					work_q <= work_q + part_w;
					part_q <= prod_q >>> 16;
				end
				UOP_ADDP: work_q <= work_q + part_w;
				UOP_DUTY: duty_q[wheel] <= prod_q[47:32];
				default: ;
			endcase
		end
	end

	always_comb begin
		res.left_duty   = duty_q[0];
		res.right_duty  = duty_q[1];
		res.left_speed  = speed_q[0];
		res.right_speed = speed_q[1];
	end

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the differential-drive wheel pid controller
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ddwp_pkg::*;

	// item kind that the block must ignore
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// settle time after draining: long enough for a tick or encoder program to finish, with margin
	localparam int SETTLE_CYCLES  = 32;
	// slowest legal gap between handshakes: tick cycles plus the longest sender gap and the
	// longest receiver stall, taken many times over
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int GAP_MAX        = 30;
	localparam int PHASES         = 7;
	localparam int PHASE_WORDS    = 200;

	localparam out_word_t RESULT_IDLE = '0;

	// wide signed scratch type, ample for every product in the controller
	typedef logic signed [127:0] wide_t;

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t res;
	} plan_row_t;

	typedef enum int {RECV_FLOW, RECV_COIN, RECV_HOLD} recv_mode_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	in_word_t          in_word   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_word_t         out_word;
	logic              cfg_we    = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [31:0]       cfg_data  = '0;

	// predictor copy of registers and controller state
	cfg_t               ctrl_regs;
	bit                 awaiting_first_sample;
	logic [31:0]        last_count [2];
	logic signed [31:0] meas_speed [2];
	logic signed [31:0] cmd_linear;
	logic signed [31:0] cmd_angular;
	logic signed [47:0] err_sum [2];
	logic signed [31:0] prev_err [2];
	logic signed [47:0] duty_acc [2];

	out_word_t expected_results [$];
	plan_row_t plan [$];

	// sender and receiver pacing
	int          burst_left;
	int          gap_max;
	recv_mode_t  recv_mode;
	int          mode_left;
	int          hold_left;
	logic [31:0] count_walk [2];

	int idle_cycles;
	int mismatch_count;

	diff_drive_wheel_pid_top i_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_word,
		.out_valid,
		.out_ready,
		.out_word,
		.cfg_we,
		.cfg_index,
		.cfg_data
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic wide_t clip(input wide_t x, input int bits);
		wide_t lim;
		lim = wide_t'(1) <<< (bits - 1);
		if (x >= lim) return lim - 1;
		if (x < -lim) return -lim;
		return x;
	endfunction

	// floor(a * g / 2^16), g unsigned
	function automatic wide_t scale_floor(input wide_t a, input logic [31:0] g);
		wide_t gw;
		gw = {96'd0, g};
		return (a * gw) >>> 16;
	endfunction

	// accumulator (1.0 = 2^32) to duty in 1/256 percent, clamped to full scale
	function automatic logic signed [15:0] duty_of(input wide_t acc);
		wide_t one, c, d;
		one = wide_t'(DUTY_ONE);
		c = (acc > one) ? one : ((acc < -one) ? -one : acc);
		d = (c * wide_t'(DUTY_FULL)) >>> 32;
		return d[15:0];
	endfunction

	task automatic clear_controller();
		ctrl_regs.speed_scale = RST_SPEED_SCALE;
		ctrl_regs.half_track  = RST_HALF_TRACK;
		ctrl_regs.gain_p      = RST_GAIN_P;
		ctrl_regs.gain_i      = RST_GAIN_I;
		ctrl_regs.gain_d      = RST_GAIN_D;
		awaiting_first_sample = 1'b1;
		cmd_linear  = '0;
		cmd_angular = '0;
		for (int i = 0; i < 2; i++) begin
			last_count[i]  = '0;
			meas_speed[i]  = '0;
			err_sum[i]     = '0;
			prev_err[i]    = '0;
			duty_acc[i]    = '0;
		end
	endtask

	task automatic advance_controller(input in_word_t w, output bit produced,
			output out_word_t res);
		wide_t turn, err, sum, term_p, term_i, term_d, tmp;
		wide_t target [2];
		logic signed [31:0] delta;
		logic [31:0] now_cnt [2];
		produced = 1'b0;
		res = '0;
		case (w.func)
			FUNC_CMD: begin
				cmd_linear  = w.linear_cmd;
				cmd_angular = w.angular_cmd;
			end
			FUNC_ENC: begin
				now_cnt[0] = w.left_count;
				now_cnt[1] = w.right_count;
				for (int i = 0; i < 2; i++) begin
					// first sample seeds the counts, so both speeds read zero
					if (awaiting_first_sample) last_count[i] = now_cnt[i];
					delta = now_cnt[i] - last_count[i];
					tmp = clip(scale_floor(-wide_t'(delta), ctrl_regs.speed_scale), 32);
					meas_speed[i] = tmp[31:0];
					last_count[i] = now_cnt[i];
				end
				awaiting_first_sample = 1'b0;
			end
			FUNC_TICK: begin
				// inverse kinematics, right wheel mounted mirrored
				turn = scale_floor(wide_t'(cmd_angular), {12'd0, ctrl_regs.half_track});
				target[0] = wide_t'(cmd_linear) - turn;
				target[1] = -(wide_t'(cmd_linear) + turn);
				for (int i = 0; i < 2; i++) begin
					err    = clip(target[i] - wide_t'(meas_speed[i]), 32);
					sum    = clip(wide_t'(err_sum[i]) + err, 48);
					term_p = clip(scale_floor(err, ctrl_regs.gain_p), 48);
					term_i = clip(scale_floor(sum, ctrl_regs.gain_i), 48);
					term_d = clip(scale_floor(err - wide_t'(prev_err[i]), ctrl_regs.gain_d), 48);
					tmp    = clip(wide_t'(duty_acc[i]) + term_p + term_i + term_d, 48);
					err_sum[i]  = sum[47:0];
					prev_err[i] = err[31:0];
					duty_acc[i] = tmp[47:0];
				end
				res.left_duty   = duty_of(wide_t'(duty_acc[0]));
				res.right_duty  = duty_of(-wide_t'(duty_acc[1]));
				res.left_speed  = meas_speed[0];
				res.right_speed = meas_speed[1];
				produced = 1'b1;
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic in_word_t word_of(input logic [1:0] f, input logic signed [31:0] lin,
			input logic signed [31:0] ang, input logic signed [31:0] lc,
			input logic signed [31:0] rc);
		return '{f, lin, ang, lc, rc};
	endfunction

	task automatic add_row(input in_word_t w, input bit typed);
		plan_row_t row;
		row.w     = w;
		row.typed = typed;
		row.res   = RESULT_IDLE;
		plan.insert(plan.size(), row);
	endtask

	// directed part: zero results after reset, extremes, wraps and ignored words
	task automatic build_plan();
		add_row(word_of(FUNC_TICK, 0, 0, 0, 0), 1'b1);
		add_row(word_of(FUNC_UNUSED, '1, '1, '1, '1), 1'b0);
		add_row(word_of(FUNC_TICK, 0, 0, 0, 0), 1'b1);
		add_row(word_of(FUNC_ENC, 0, 0, 12345, -777), 1'b0);
		add_row(word_of(FUNC_TICK, 0, 0, 0, 0), 1'b1);
		add_row(word_of(FUNC_ENC, 0, 0, 12445, -877), 1'b0);
		add_row(word_of(FUNC_TICK, 0, 0, 0, 0), 1'b0);
		add_row(word_of(FUNC_CMD, 32'h7fff_ffff, 0, 0, 0), 1'b0);
		add_row(word_of(FUNC_TICK, 0, 0, 0, 0), 1'b0);
		add_row(word_of(FUNC_CMD, 32'h8000_0000, 32'h7fff_ffff, 0, 0), 1'b0);
		add_row(word_of(FUNC_TICK, 0, 0, 0, 0), 1'b0);
		add_row(word_of(FUNC_CMD, 0, 32'h8000_0000, 0, 0), 1'b0);
		add_row(word_of(FUNC_TICK, 0, 0, 0, 0), 1'b0);
		add_row(word_of(FUNC_ENC, 0, 0, 32'h7fff_ffff, 32'h8000_0000), 1'b0);
		add_row(word_of(FUNC_ENC, 0, 0, 32'h8000_0000, 32'h7fff_ffff), 1'b0);
		add_row(word_of(FUNC_TICK, 0, 0, 0, 0), 1'b0);
		add_row(word_of(FUNC_ENC, 0, 0, 0, 0), 1'b0);
		add_row(word_of(FUNC_CMD, 65536, 65536, 0, 0), 1'b0);
		add_row(word_of(FUNC_TICK, 0, 0, 0, 0), 1'b0);
		add_row(word_of(FUNC_TICK, 0, 0, 0, 0), 1'b0);
		add_row(word_of(FUNC_TICK, 0, 0, 0, 0), 1'b0);
		add_row(word_of(FUNC_UNUSED, 0, 0, 0, 0), 1'b0);
		add_row(word_of(FUNC_TICK, 0, 0, 0, 0), 1'b0);
	endtask

	// mostly plausible commands and encoder walks, some full-range noise
	function automatic in_word_t next_stimulus();
		in_word_t w;
		int pick;
		bit noise;
		pick = $urandom_range(0, 99);
		noise = ($urandom_range(0, 9) == 0);
		w.linear_cmd  = $urandom;
		w.angular_cmd = $urandom;
		w.left_count  = $urandom;
		w.right_count = $urandom;
		if (pick < 5) begin
			w.func = FUNC_UNUSED;
		end else if (pick < 25) begin
			w.func = FUNC_CMD;
			if (!noise) begin
				// about +-2 m/s and +-3 rad/s
				w.linear_cmd  = int'($urandom_range(0, 262144)) - 131072;
				w.angular_cmd = int'($urandom_range(0, 393216)) - 196608;
			end
		end else if (pick < 60) begin
			w.func = FUNC_ENC;
			if (noise) begin
				count_walk[0] = w.left_count;
				count_walk[1] = w.right_count;
			end else begin
				count_walk[0] = count_walk[0] + $urandom_range(0, 4000) - 2000;
				count_walk[1] = count_walk[1] + $urandom_range(0, 4000) - 2000;
				w.left_count  = count_walk[0];
				w.right_count = count_walk[1];
			end
		end else begin
			w.func = FUNC_TICK;
		end
		return w;
	endfunction

	function automatic cfg_t random_settings();
		cfg_t s;
		logic [31:0] r;
		r = $urandom;
		s.speed_scale = $urandom;
		s.half_track  = r[19:0];
		s.gain_p      = $urandom;
		s.gain_i      = $urandom;
		s.gain_d      = $urandom;
		return s;
	endfunction

	// ---------------------------------------------------------------- drivers

	// sender works in bursts; a new burst may start after a random gap
	task automatic send_word(input in_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	// hold the sender until every expected word has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic quiesce();
		drain_results();
		// an encoder word may still be busy with no result to show for it
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SPEED_SCALE: ctrl_regs.speed_scale = data;
			REG_HALF_TRACK:  ctrl_regs.half_track  = data[19:0];
			REG_GAIN_P:      ctrl_regs.gain_p      = data;
			REG_GAIN_I:      ctrl_regs.gain_i      = data;
			REG_GAIN_D:      ctrl_regs.gain_d      = data;
			default: ;
		endcase
	endtask

	task automatic load_settings(input cfg_t s);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(REG_SPEED_SCALE, s.speed_scale);
		// bits above the 20-bit track width must be dropped
		write_reg(REG_HALF_TRACK, {junk[31:20], s.half_track});
		write_reg(REG_GAIN_P, s.gain_p);
		write_reg(REG_GAIN_I, s.gain_i);
		write_reg(REG_GAIN_D, s.gain_d);
		// indexes past the last register are ignored
		for (int k = int'(REG_GAIN_D) + 1; k < (1 << CIDX_W); k++) begin
			write_reg(k[CIDX_W-1:0], $urandom);
		end
	endtask

	// receiver: stretches of full flow, coin-flip stalls and long holds
	always @(posedge clk) begin
		if (mode_left == 0) begin
			mode_left = $urandom_range(40, 400);
			recv_mode = recv_mode_t'($urandom_range(0, 2));
		end
		mode_left--;
		case (recv_mode)
			RECV_FLOW: out_ready <= 1'b1;
			RECV_COIN: out_ready <= 1'($urandom_range(0, 1));
			default: begin
				if (hold_left > 0) begin
					hold_left--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
					if ($urandom_range(0, 5) == 0) hold_left = $urandom_range(1, 40);
				end
			end
		endcase
	end

	// ---------------------------------------------------------------- checking

	task automatic log_mismatch(input string what, input out_word_t want, input out_word_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t %s: expected duty %0d/%0d speed %0d/%0d, got duty %0d/%0d speed %0d/%0d",
				$time, what, want.left_duty, want.right_duty, want.left_speed, want.right_speed,
				got.left_duty, got.right_duty, got.left_speed, got.right_speed);
		end
	endtask

	// compare each result word with the oldest expectation; watchdog on handshakes
	always @(posedge clk) begin : check_results
		out_word_t want;
		string diffs;
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				log_mismatch("result word with nothing expected", RESULT_IDLE, out_word);
			end else begin
				want = expected_results.pop_front();
				diffs = "";
				if (want.left_duty !== out_word.left_duty) diffs = {diffs, " left_duty"};
				if (want.right_duty !== out_word.right_duty) diffs = {diffs, " right_duty"};
				if (want.left_speed !== out_word.left_speed) diffs = {diffs, " left_speed"};
				if (want.right_speed !== out_word.right_speed) diffs = {diffs, " right_speed"};
				if (diffs != "") log_mismatch({"mismatch in", diffs}, want, out_word);
			end
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		cfg_t settings [PHASES];
		in_word_t w;
		bit produced;
		out_word_t res;
		int sent;

		burst_left     = 0;
		gap_max        = GAP_MAX;
		mode_left      = 0;
		hold_left      = 0;
		idle_cycles    = 0;
		mismatch_count = 0;
		count_walk[0]  = $urandom;
		count_walk[1]  = $urandom;
		clear_controller();
		build_plan();

		// phase 0 runs on reset values, the others load a full register set
		settings[0] = ctrl_regs;
		settings[1] = '0;
		settings[2] = '1;
		settings[3] = random_settings();
		settings[4] = settings[0];
		settings[5] = random_settings();
		settings[6].speed_scale = 32'h0010_0000;
		settings[6].half_track  = 20'h1_0000;
		settings[6].gain_p      = 32'h8000_0000;
		settings[6].gain_i      = 32'h0100_0000;
		settings[6].gain_d      = 32'h1000_0000;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) load_settings(settings[p]);
			// one phase in which the sender leaves no gap between bursts
			gap_max = (p == 2) ? 0 : GAP_MAX;
			if (p == 0) begin
				foreach (plan[k]) begin
					send_word(plan[k].w);
					advance_controller(plan[k].w, produced, res);
					if (produced) begin
						expected_results.insert(expected_results.size(),
							plan[k].typed ? plan[k].res : res);
					end
				end
				drain_results();
			end
			sent = 0;
			while (sent < PHASE_WORDS) begin
				w = next_stimulus();
				send_word(w);
				advance_controller(w, produced, res);
				if (produced) expected_results.insert(expected_results.size(), res);
				if (w.func != FUNC_UNUSED) sent++;
				if ($urandom_range(0, 149) == 0) drain_results();
			end
			quiesce();
		end

		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
